/* rtl/core/bbd_pkg.sv */
// Shared constants and types for the bilinear Bayer demosaic core.
`default_nettype none
package bbd_pkg;
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIN_DEPTH  = 2 * MAX_WIDTH + 3;
	localparam int PTR_W      = $clog2(WIN_DEPTH);
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FILL_W     = $clog2(MAX_WIDTH + 2);
	localparam int RW_REG_W   = 12;
	localparam int FH_REG_W   = 13;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [0:0] {
		REG_ROW_WIDTH    = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [7:0] pix_t;
	// [2] newest sample of the triple, [0] oldest
	typedef pix_t [2:0] trip_t;
	// [2] row below the pixel, [1] pixel row, [0] row above
	typedef trip_t [2:0] win_t;

	typedef struct packed {
		logic px;
		logic py;
		logic border;
		logic last;
	} pos_t;
endpackage
`default_nettype wire

/* rtl/core/bbd_window.sv */
// Line store of sample triples with two registered read ports forming a 3x3 window.
`default_nettype none
module bbd_window (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 wr_en,
	input  wire bbd_pkg::pix_t        wr_sample,
	input  wire logic [bbd_pkg::WW-1:0] width,
	output bbd_pkg::win_t             win
);
	localparam int D = bbd_pkg::WIN_DEPTH;
	localparam int AW = bbd_pkg::PTR_W + 1;

	bbd_pkg::trip_t mem [D];
	logic [bbd_pkg::PTR_W-1:0] ptr_q;
	bbd_pkg::pix_t hist_q [2];
	bbd_pkg::trip_t entry;
	bbd_pkg::trip_t top_s1, mid_s1, old_s1;
	logic [AW-1:0] ptr_x, w1, w2, mid_a, old_a;
	logic [bbd_pkg::PTR_W-1:0] mid_addr, old_addr;

	assign entry = {wr_sample, hist_q[0], hist_q[1]};
	assign ptr_x = AW'(ptr_q);
	assign w1    = AW'(width);
	assign w2    = AW'({width, 1'b0});
	assign mid_a = (ptr_x >= w1) ? ptr_x - w1 : ptr_x + AW'(D) - w1;
	assign old_a = (ptr_x >= w2) ? ptr_x - w2 : ptr_x + AW'(D) - w2;
	assign mid_addr = mid_a[bbd_pkg::PTR_W-1:0];
	assign old_addr = old_a[bbd_pkg::PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (wr_en) begin
			ptr_q <= (ptr_q == bbd_pkg::PTR_W'(D - 1)) ? '0 : ptr_q + bbd_pkg::PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= entry;
			hist_q[0]  <= wr_sample;
			hist_q[1]  <= hist_q[0];
		end
		if (adv) begin
			mid_s1 <= mem[mid_addr];
			old_s1 <= mem[old_addr];
			top_s1 <= entry;
		end
	end

	assign win = {top_s1, mid_s1, old_s1};
endmodule
`default_nettype wire

/* rtl/core/bbd_interp.sv */
// Bilinear and border interpolation of one pixel from its 3x3 window.
`default_nettype none
module bbd_interp (
	input  wire bbd_pkg::win_t win,
	input  wire bbd_pkg::pos_t pos,
	output bbd_pkg::pix_t      red,
	output bbd_pkg::pix_t      green,
	output bbd_pkg::pix_t      blue
);
	function automatic bbd_pkg::pix_t avg2(bbd_pkg::pix_t a, bbd_pkg::pix_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic bbd_pkg::pix_t avg4(bbd_pkg::pix_t a, bbd_pkg::pix_t b,
			bbd_pkg::pix_t c, bbd_pkg::pix_t d);
		logic [9:0] s;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
		return s[9:2];
	endfunction

	logic [1:0] r0, r1, c0, c1;
	bbd_pkg::pix_t g00, g11;

	// block-origin offsets relative to the pixel inside its 2x2 block
	assign r1 = 2'd2 - {1'b0, pos.py};
	assign r0 = 2'd1 - {1'b0, pos.py};
	assign c1 = 2'd2 - {1'b0, pos.px};
	assign c0 = 2'd1 - {1'b0, pos.px};
	assign g00 = win[r0][c0];
	assign g11 = win[r1][c1];

	always_comb begin
		if (pos.border) begin
			red  = win[r1][c0];
			blue = win[r0][c1];
			if (pos.px == pos.py) green = pos.px ? g11 : g00;
			else                  green = avg2(g00, g11);
		end else begin
			unique case ({pos.py, pos.px})
				2'b00: begin
					red   = avg2(win[2][1], win[0][1]);
					green = win[1][1];
					blue  = avg2(win[1][0], win[1][2]);
				end
				2'b10: begin
					red   = win[1][1];
					green = avg4(win[0][1], win[2][1], win[1][0], win[1][2]);
					blue  = avg4(win[0][2], win[0][0], win[2][2], win[2][0]);
				end
				2'b01: begin
					red   = avg4(win[2][0], win[2][2], win[0][0], win[0][2]);
					green = avg4(win[1][0], win[1][2], win[0][1], win[2][1]);
					blue  = win[1][1];
				end
				default: begin
					red   = avg2(win[1][0], win[1][2]);
					green = win[1][1];
					blue  = avg2(win[0][1], win[2][1]);
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bayer_bilinear_demosaic_core.sv */
// Top level of the streaming bilinear demosaic for a GBRG mosaic.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   sample, frame_start, pad
//  out      source     out_valid / out_stall red, green, blue, frame_end
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
// One sample beat is taken every cycle unless out_stall holds the pipe; the line store
// gives two reads per cycle (rows above and at the pixel), so no beat waits on the store.
// A pixel passes two register stages (window stage, output registers) after the beat that
// completes its window is accepted; that beat is row_width+1 positions after its sample.
// Reset clears position counters; the line store is not cleared.
// out_stall freezes the whole pipe; in_stall is raised while a result waits.
`default_nettype none
module bayer_bilinear_demosaic_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     sample,
	input  wire logic                           frame_start,
	input  wire logic                           pad,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                frame_end,
	input  wire logic                           cfg_we,
	input  wire logic [0:0]                     cfg_index,
	input  wire logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int WW    = bbd_pkg::WW;
	localparam int HW    = bbd_pkg::HW;
	localparam int COL_W = bbd_pkg::COL_W;
	localparam int ROW_W = bbd_pkg::ROW_W;
	localparam int FW    = bbd_pkg::FILL_W;

	logic [bbd_pkg::RW_REG_W-1:0] width_q, wm;
	logic [bbd_pkg::FH_REG_W-1:0] height_q, hm;
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [COL_W-1:0] col_q, col0, c, col_n;
	logic [ROW_W-1:0] row_q, row0, r, row_n;
	logic [FW-1:0] fill_q, fill0, fill_n;
	logic done_q, done0, done_n;
	logic adv, acc, emit;
	logic [COL_W-1:0] x;
	logic [ROW_W-1:0] y;
	logic [HW-1:0] r_inc;
	bbd_pkg::pos_t pos, pos_s1;
	logic v_s1;
	bbd_pkg::win_t win;
	bbd_pkg::pix_t red_c, green_c, blue_c, wr_sample;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbd_pkg::RW_REG_W'(640);
			height_q <= bbd_pkg::FH_REG_W'(480);
		end else if (cfg_we) begin
			unique case (bbd_pkg::reg_idx_t'(cfg_index))
				bbd_pkg::REG_ROW_WIDTH:    width_q  <= cfg_data[bbd_pkg::RW_REG_W-1:0];
				bbd_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[bbd_pkg::FH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// force even, saturate to the supported range
	assign wm = {width_q[bbd_pkg::RW_REG_W-1:1], 1'b0};
	assign hm = {height_q[bbd_pkg::FH_REG_W-1:1], 1'b0};
	assign w = (32'(wm) < 2) ? WW'(2) :
		(32'(wm) > bbd_pkg::MAX_WIDTH) ? WW'(bbd_pkg::MAX_WIDTH) : WW'(wm);
	assign h = (32'(hm) < 2) ? HW'(2) :
		(32'(hm) > bbd_pkg::MAX_HEIGHT) ? HW'(bbd_pkg::MAX_HEIGHT) : HW'(hm);

	assign col0  = frame_start ? '0 : col_q;
	assign row0  = frame_start ? '0 : row_q;
	assign fill0 = frame_start ? '0 : fill_q;
	assign done0 = frame_start ? 1'b0 : done_q;
	assign emit  = !done0 && (fill0 >= FW'(w) + FW'(1));

	assign c = (WW'(col0) < w) ? col0 : COL_W'(w - WW'(1));
	assign r = (HW'(row0) < h) ? row0 : ROW_W'(h - HW'(1));
	assign x = {c[COL_W-1:1], 1'b0};
	assign y = {r[ROW_W-1:1], 1'b0};
	assign r_inc = HW'(r) + HW'(1);

	assign pos.px     = c[0];
	assign pos.py     = r[0];
	assign pos.border = (x == '0) || (y == '0) || (WW'(x) == w - WW'(2)) ||
		(HW'(y) == h - HW'(2));
	assign pos.last   = (WW'(c) == w - WW'(1)) && (HW'(r) == h - HW'(1));

	always_comb begin
		col_n  = col0;
		row_n  = row0;
		fill_n = fill0;
		done_n = done0;
		if (!done0) begin
			if (!emit) begin
				fill_n = fill0 + FW'(1);
			end else if (WW'(c) + WW'(1) == w) begin
				col_n = '0;
				if (r_inc >= h) begin
					row_n  = '0;
					done_n = 1'b1;
				end else begin
					row_n = ROW_W'(r_inc);
				end
			end else begin
				col_n = c + COL_W'(1);
				row_n = r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
			done_q <= 1'b0;
		end else if (acc) begin
			col_q  <= col_n;
			row_q  <= row_n;
			fill_q <= fill_n;
			done_q <= done_n;
		end
	end

	assign wr_sample = pad ? '0 : sample;

	bbd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.wr_en     (acc),
		.wr_sample (wr_sample),
		.width     (w),
		.win       (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) pos_s1 <= pos;
	end

	bbd_interp u_interp (
		.win   (win),
		.pos   (pos_s1),
		.red   (red_c),
		.green (green_c),
		.blue  (blue_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			red       <= red_c;
			green     <= green_c;
			blue      <= blue_c;
			frame_end <= pos_s1.last;
		end
	end

	a_start_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frame_start |=> !v_s1)
		else $error("pixel issued on the beat that starts a frame");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && done_q && !frame_start |=> !v_s1)
		else $error("pixel issued after the frame completed");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(pos_s1))
		else $error("window stage lost its pixel during a stall");
endmodule
`default_nettype wire
